// File: src/i2cms_pkg.sv
// i2cms_pkg: shared types and codes for the I2C master bit sequencer.
// No dependencies; used by the sequencer and the testbench.
`default_nettype none

package i2cms_pkg;

   localparam int TIMEOUT_BITS_DEFAULT = 16;

   // command codes
   localparam logic [2:0] CMD_START     = 3'd0;
   localparam logic [2:0] CMD_STOP      = 3'd1;
   localparam logic [2:0] CMD_WRITE     = 3'd2;
   localparam logic [2:0] CMD_READ      = 3'd3;
   localparam logic [2:0] CMD_WAIT_ACK  = 3'd4;

   // wait-ack status codes
   localparam logic [1:0] STAT_ACKED    = 2'd0;
   localparam logic [1:0] STAT_TIMEOUT  = 2'd1;
   localparam logic [1:0] STAT_NOT_LOW  = 2'd2;

   typedef struct packed {
      logic        cmd_valid;
      logic [2:0]  command;
      logic [7:0]  tx_byte;
      logic        ack_after_read;
      logic [15:0] ack_timeout;
      logic        sda_in;
   } req_type;

   typedef struct packed {
      logic        scl_out;
      logic        sda_out;
      logic        busy_res;
      logic        done_res;
      logic [7:0]  rx_byte;
      logic [1:0]  ack_status;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/i2cms_chan_if.sv
// i2cms_chan_if: valid/ready channel carrying one payload per transaction.
// Payload type is supplied by the instantiating level (see i2cms_pkg).
`default_nettype none

interface i2cms_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/i2c_master_bit_sequencer.sv
// i2c_master_bit_sequencer: timed I2C master SCL/SDA sequencer, one tick per transaction.
// Depends on i2cms_pkg and i2cms_chan_if.
//
// Pipeline: input register, then result register, between a request transaction and its response.
// Throughput: one tick per cycle while the response channel does not stall; the sequencer step is combinational.
// Reset: synchronous, active high; sequencer idle, SCL/SDA released, rx byte and status zero.
`default_nettype none

module i2c_master_bit_sequencer #(
   parameter int TIMEOUT_BITS = i2cms_pkg::TIMEOUT_BITS_DEFAULT
) (
   input  wire           clock,
   input  wire           reset,
   i2cms_chan_if.sink    req_chan,
   i2cms_chan_if.source  rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ST_A, ST_ST_B, ST_SP_A, ST_SP_B, ST_WR_LO, ST_WR_HI,
      ST_RD_PRE, ST_RD_LO, ST_RD_HI, ST_RD_ACK_HI, ST_RD_ACK_LO,
      ST_WA_POLL, ST_WA_HI, ST_WA_LO
   } state_type;

   // input stage
   logic                   in_vld_ff;
   i2cms_pkg::req_type     in_data_ff;
   // result stage
   logic                   rsp_vld_ff;
   i2cms_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   // sequencer state
   state_type              state_ff, state_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [2:0]             bit_idx_ff, bit_idx_in;
   logic [7:0]             shift_ff, shift_in;
   logic [TIMEOUT_BITS-1:0] budget_ff, budget_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;
   logic                   ack_choice_ff, ack_choice_in;
   logic [1:0]             status_ff, status_in;
   logic [7:0]             rx_ff, rx_in;

   logic                   advance;
   logic                   phase_last;
   logic                   scl_now, sda_now, busy, done;
   state_type              nxt;

   assign advance        = in_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      bit_idx_in    = bit_idx_ff;
      shift_in      = shift_ff;
      budget_in     = budget_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      ack_choice_in = ack_choice_ff;
      status_in     = status_ff;
      rx_in         = rx_ff;
      busy          = 1'b0;
      done          = 1'b0;
      phase_last    = 1'b0;
      nxt           = ST_IDLE;

      // command accepted only while idle; unknown codes are dropped
      if (state_ff == ST_IDLE && in_data_ff.cmd_valid &&
          in_data_ff.command <= i2cms_pkg::CMD_WAIT_ACK) begin
         cnt_in     = 2'd0;
         bit_idx_in = 3'd7;
         unique case (in_data_ff.command)
            i2cms_pkg::CMD_START: begin
               scl_in = 1'b1; sda_in = 1'b1; state_in = ST_ST_A;
            end
            i2cms_pkg::CMD_STOP: begin
               scl_in = 1'b0; sda_in = 1'b0; state_in = ST_SP_A;
            end
            i2cms_pkg::CMD_WRITE: begin
               shift_in = in_data_ff.tx_byte;
               scl_in   = 1'b0;
               sda_in   = in_data_ff.tx_byte[7];
               state_in = ST_WR_LO;
            end
            i2cms_pkg::CMD_READ: begin
               ack_choice_in = in_data_ff.ack_after_read;
               shift_in      = 8'd0;
               scl_in        = 1'b0;
               state_in      = ST_RD_PRE;
            end
            default: begin
               budget_in = TIMEOUT_BITS'(in_data_ff.ack_timeout);
               state_in  = ST_WA_POLL;
            end
         endcase
      end

      // pins show the levels held during this tick
      scl_now = scl_in;
      sda_now = sda_in;

      if (state_in != ST_IDLE) begin
         busy = 1'b1;
         if (state_in == ST_RD_HI && cnt_in == 2'd0 && in_data_ff.sda_in) begin
            shift_in[bit_idx_in] = 1'b1;
         end
         if (state_in == ST_ST_A || state_in == ST_ST_B ||
             state_in == ST_SP_A || state_in == ST_SP_B) begin
            phase_last = (cnt_in == 2'd3);
         end else begin
            phase_last = (cnt_in == 2'd1);
         end
         cnt_in = cnt_in + 2'd1;
         if (phase_last) begin
            cnt_in = 2'd0;
            case (state_in)
               ST_ST_A:  begin sda_in = 1'b0; nxt = ST_ST_B; end
               ST_ST_B:  begin scl_in = 1'b0; done = 1'b1; end
               ST_SP_A:  begin scl_in = 1'b1; sda_in = 1'b1; nxt = ST_SP_B; end
               ST_SP_B:  done = 1'b1;
               ST_WR_LO: begin scl_in = 1'b1; nxt = ST_WR_HI; end
               ST_WR_HI: begin
                  scl_in = 1'b0;
                  if (bit_idx_in == 3'd0) begin
                     sda_in = 1'b1;
                     done   = 1'b1;
                  end else begin
                     bit_idx_in = bit_idx_in - 3'd1;
                     sda_in     = shift_in[bit_idx_in];
                     nxt        = ST_WR_LO;
                  end
               end
               ST_RD_PRE: begin sda_in = 1'b1; nxt = ST_RD_LO; end
               ST_RD_LO:  begin scl_in = 1'b1; nxt = ST_RD_HI; end
               ST_RD_HI: begin
                  if (bit_idx_in == 3'd0) begin
                     sda_in = !ack_choice_in;
                     scl_in = 1'b1;
                     nxt    = ST_RD_ACK_HI;
                  end else begin
                     bit_idx_in = bit_idx_in - 3'd1;
                     scl_in     = 1'b0;
                     nxt        = ST_RD_LO;
                  end
               end
               ST_RD_ACK_HI: begin scl_in = 1'b0; sda_in = 1'b1; nxt = ST_RD_ACK_LO; end
               ST_RD_ACK_LO: begin rx_in = shift_in; done = 1'b1; end
               ST_WA_POLL: begin
                  // exhausted budget wins over a low SDA
                  if (budget_in == '0) begin
                     status_in = i2cms_pkg::STAT_TIMEOUT;
                     done      = 1'b1;
                  end else begin
                     budget_in = budget_in - TIMEOUT_BITS'(1);
                     if (in_data_ff.sda_in) begin
                        nxt = ST_WA_POLL;
                     end else begin
                        scl_in = 1'b1;
                        nxt    = ST_WA_HI;
                     end
                  end
               end
               ST_WA_HI: begin
                  if (in_data_ff.sda_in) begin
                     status_in = i2cms_pkg::STAT_NOT_LOW;
                     done      = 1'b1;
                  end else begin
                     scl_in = 1'b0;
                     nxt    = ST_WA_LO;
                  end
               end
               default: begin
                  status_in = i2cms_pkg::STAT_ACKED;
                  done      = 1'b1;
               end
            endcase
            state_in = nxt;
         end
      end

      rsp_data_in.scl_out    = scl_now;
      rsp_data_in.sda_out    = sda_now;
      rsp_data_in.busy_res   = busy;
      rsp_data_in.done_res   = done;
      rsp_data_in.rx_byte    = rx_in;
      rsp_data_in.ack_status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         state_ff      <= ST_IDLE;
         cnt_ff        <= 2'd0;
         bit_idx_ff    <= 3'd7;
         shift_ff      <= 8'd0;
         budget_ff     <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_choice_ff <= 1'b0;
         status_ff     <= i2cms_pkg::STAT_ACKED;
         rx_ff         <= 8'd0;
      end else begin
         if (req_chan.ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_vld_ff    <= 1'b1;
            state_ff      <= state_in;
            cnt_ff        <= cnt_in;
            bit_idx_ff    <= bit_idx_in;
            shift_ff      <= shift_in;
            budget_ff     <= budget_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            ack_choice_ff <= ack_choice_in;
            status_ff     <= status_in;
            rx_ff         <= rx_in;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // phase counter only passes 1 in the 4-tick start/stop phases
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff[1] |-> (state_ff == ST_ST_A || state_ff == ST_ST_B ||
                     state_ff == ST_SP_A || state_ff == ST_SP_B))
      else $error("phase count out of range for state");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> cnt_ff == 2'd0)
      else $error("phase count not cleared in idle");

   // a finished sequence leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      advance && done |=> state_ff == ST_IDLE)
      else $error("sequence done but not idle");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("stepped tick produced no response");

   assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff)
      else $error("held tick dropped from input stage");

endmodule

`default_nettype wire

// File: tb/i2c_master_bit_sequencer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for i2c_master_bit_sequencer: a tick-level predictor of the
// SCL/SDA sequencer, with a scripted opening and then randomized bus transfers.
// Depends on i2cms_pkg, i2cms_chan_if and the i2c_master_bit_sequencer RTL.

module i2c_master_bit_sequencer_test;

   localparam int RANDOM_TICKS = 330;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_OFF     = 300;

   typedef enum logic [3:0] {
      SQ_IDLE, SQ_START_A, SQ_START_B, SQ_STOP_A, SQ_STOP_B, SQ_WR_LO, SQ_WR_HI,
      SQ_RD_PRE, SQ_RD_LO, SQ_RD_HI, SQ_ACK_HI, SQ_ACK_LO, SQ_POLL, SQ_POLL_HI, SQ_POLL_LO
   } seq_state_type;

   // One bus command plus the slave's SDA behavior while it runs. For a wait ack the
   // slave pulls SDA low for ticks low_from .. low_to-1, counted from the command tick.
   typedef struct packed {
      logic        go;
      logic [2:0]  op;
      logic [7:0]  wr_data;
      logic        send_ack;
      logic [15:0] polls;
      logic [7:0]  rd_data;
      logic [7:0]  low_from;
      logic [7:0]  low_to;
      logic        typed;
      logic [7:0]  exp_rx;
      logic [1:0]  exp_stat;
   } bus_op_type;

   // typed rows: rx byte and status on the final tick are given here, not predicted
   localparam bus_op_type SCRIPT [17] = '{
      '{1'b0, i2cms_pkg::CMD_START,    8'h00, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0,
        1'b1, 8'h00, i2cms_pkg::STAT_ACKED},
      '{1'b1, i2cms_pkg::CMD_START,    8'h00, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0,
        1'b1, 8'h00, i2cms_pkg::STAT_ACKED},
      '{1'b1, i2cms_pkg::CMD_WRITE,    8'h00, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0,
        1'b0, 8'h00, i2cms_pkg::STAT_ACKED},
      '{1'b1, i2cms_pkg::CMD_WRITE,    8'hFF, 1'b1, 16'hFFFF, 8'hFF, 8'd0, 8'd0,
        1'b0, 8'h00, i2cms_pkg::STAT_ACKED},
      '{1'b1, i2cms_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0,
        1'b1, 8'h00, i2cms_pkg::STAT_TIMEOUT},
      '{1'b1, i2cms_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd255,
        1'b1, 8'h00, i2cms_pkg::STAT_TIMEOUT},
      '{1'b1, i2cms_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 16'hFFFF, 8'h00, 8'd0, 8'd255,
        1'b1, 8'h00, i2cms_pkg::STAT_ACKED},
      '{1'b1, i2cms_pkg::CMD_READ,     8'h00, 1'b1, 16'h0000, 8'hFF, 8'd0, 8'd0,
        1'b1, 8'hFF, i2cms_pkg::STAT_ACKED},
      '{1'b1, i2cms_pkg::CMD_READ,     8'hFF, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0,
        1'b1, 8'h00, i2cms_pkg::STAT_ACKED},
      '{1'b1, i2cms_pkg::CMD_WRITE,    8'hA5, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0,
        1'b0, 8'h00, i2cms_pkg::STAT_ACKED},
      '{1'b1, i2cms_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 16'h0003, 8'h00, 8'd1, 8'd2,
        1'b1, 8'h00, i2cms_pkg::STAT_NOT_LOW},
      '{1'b1, i2cms_pkg::CMD_READ,     8'h00, 1'b1, 16'h0000, 8'h5A, 8'd0, 8'd0,
        1'b1, 8'h5A, i2cms_pkg::STAT_NOT_LOW},
      '{1'b1, i2cms_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 16'h0002, 8'h00, 8'd0, 8'd0,
        1'b1, 8'h5A, i2cms_pkg::STAT_TIMEOUT},
      '{1'b1, i2cms_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 16'h0005, 8'h00, 8'd6, 8'd100,
        1'b1, 8'h5A, i2cms_pkg::STAT_ACKED},
      '{1'b1, 3'd5,                    8'hFF, 1'b1, 16'hFFFF, 8'h00, 8'd0, 8'd0,
        1'b1, 8'h5A, i2cms_pkg::STAT_ACKED},
      '{1'b1, 3'd7,                    8'h00, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0,
        1'b1, 8'h5A, i2cms_pkg::STAT_ACKED},
      '{1'b1, i2cms_pkg::CMD_STOP,     8'h00, 1'b0, 16'h0000, 8'h00, 8'd0, 8'd0,
        1'b0, 8'h00, i2cms_pkg::STAT_ACKED}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cms_chan_if #(.payload_type(i2cms_pkg::req_type)) req_if ();
   i2cms_chan_if #(.payload_type(i2cms_pkg::rsp_type)) rsp_if ();

   i2c_master_bit_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted sequencer state
   seq_state_type seq;
   logic [2:0]  tick_cnt;
   logic [2:0]  bit_pos;
   logic [7:0]  shreg;
   logic [7:0]  rx_hold;
   logic [16:0] budget;
   logic        scl_lvl;
   logic        sda_lvl;
   logic        ack_sel;
   logic [1:0]  status;

   i2cms_pkg::rsp_type bus_levels_q [$];
   int          failures    = 0;
   int          rsp_seen    = 0;
   int          busy_ticks  = 0;
   int          burst_left  = 0;
   int          stall_cycles = 0;

   // Advances the predicted sequencer by one tick and returns the pin levels and status.
   function automatic i2cms_pkg::rsp_type bus_tick(input i2cms_pkg::req_type r);
      i2cms_pkg::rsp_type o;
      seq_state_type      s;
      seq_state_type      nxt;
      logic [2:0]         plen;
      if (seq == SQ_IDLE && r.cmd_valid && r.command <= i2cms_pkg::CMD_WAIT_ACK) begin
         tick_cnt = 3'd0;
         bit_pos  = 3'd7;
         case (r.command)
            i2cms_pkg::CMD_START: begin
               scl_lvl = 1'b1;
               sda_lvl = 1'b1;
               seq     = SQ_START_A;
            end
            i2cms_pkg::CMD_STOP: begin
               scl_lvl = 1'b0;
               sda_lvl = 1'b0;
               seq     = SQ_STOP_A;
            end
            i2cms_pkg::CMD_WRITE: begin
               shreg   = r.tx_byte;
               scl_lvl = 1'b0;
               sda_lvl = r.tx_byte[7];
               seq     = SQ_WR_LO;
            end
            i2cms_pkg::CMD_READ: begin
               ack_sel = r.ack_after_read;
               shreg   = 8'h00;
               scl_lvl = 1'b0;
               seq     = SQ_RD_PRE;
            end
            default: begin
               budget = {1'b0, r.ack_timeout};
               seq    = SQ_POLL;
            end
         endcase
      end
      o.scl_out  = scl_lvl;
      o.sda_out  = sda_lvl;
      o.busy_res = 1'b0;
      o.done_res = 1'b0;
      if (seq != SQ_IDLE) begin
         s = seq;
         o.busy_res = 1'b1;
         // read data is sampled on the first tick of the SCL-high half
         if (s == SQ_RD_HI && tick_cnt == 3'd0 && r.sda_in)
            shreg[bit_pos] = 1'b1;
         tick_cnt = tick_cnt + 3'd1;
         plen = (s == SQ_START_A || s == SQ_START_B || s == SQ_STOP_A || s == SQ_STOP_B)
                ? 3'd4 : 3'd2;
         if (tick_cnt >= plen) begin
            tick_cnt = 3'd0;
            nxt = SQ_IDLE;
            case (s)
               SQ_START_A: begin
                  sda_lvl = 1'b0;
                  nxt = SQ_START_B;
               end
               SQ_START_B: begin
                  scl_lvl = 1'b0;
                  o.done_res = 1'b1;
               end
               SQ_STOP_A: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b1;
                  nxt = SQ_STOP_B;
               end
               SQ_STOP_B: o.done_res = 1'b1;
               SQ_WR_LO: begin
                  scl_lvl = 1'b1;
                  nxt = SQ_WR_HI;
               end
               SQ_WR_HI: begin
                  scl_lvl = 1'b0;
                  if (bit_pos == 3'd0) begin
                     sda_lvl = 1'b1;
                     o.done_res = 1'b1;
                  end else begin
                     bit_pos = bit_pos - 3'd1;
                     sda_lvl = shreg[bit_pos];
                     nxt = SQ_WR_LO;
                  end
               end
               SQ_RD_PRE: begin
                  sda_lvl = 1'b1;
                  nxt = SQ_RD_LO;
               end
               SQ_RD_LO: begin
                  scl_lvl = 1'b1;
                  nxt = SQ_RD_HI;
               end
               SQ_RD_HI: begin
                  if (bit_pos == 3'd0) begin
                     sda_lvl = !ack_sel;
                     scl_lvl = 1'b1;
                     nxt = SQ_ACK_HI;
                  end else begin
                     bit_pos = bit_pos - 3'd1;
                     scl_lvl = 1'b0;
                     nxt = SQ_RD_LO;
                  end
               end
               SQ_ACK_HI: begin
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b1;
                  nxt = SQ_ACK_LO;
               end
               SQ_ACK_LO: begin
                  rx_hold = shreg;
                  o.done_res = 1'b1;
               end
               SQ_POLL: begin
                  // an exhausted budget wins over a low SDA
                  if (budget == 17'd0) begin
                     status = i2cms_pkg::STAT_TIMEOUT;
                     o.done_res = 1'b1;
                  end else begin
                     budget = budget - 17'd1;
                     if (r.sda_in) begin
                        nxt = SQ_POLL;
                     end else begin
                        scl_lvl = 1'b1;
                        nxt = SQ_POLL_HI;
                     end
                  end
               end
               SQ_POLL_HI: begin
                  if (r.sda_in) begin
                     status = i2cms_pkg::STAT_NOT_LOW;
                     o.done_res = 1'b1;
                  end else begin
                     scl_lvl = 1'b0;
                     nxt = SQ_POLL_LO;
                  end
               end
               default: begin
                  status = i2cms_pkg::STAT_ACKED;
                  o.done_res = 1'b1;
               end
            endcase
            seq = nxt;
         end
      end
      o.rx_byte    = rx_hold;
      o.ack_status = status;
      return o;
   endfunction

   function automatic bus_op_type rand_op(input logic [2:0] op);
      bus_op_type o;
      o.go       = 1'b1;
      o.op       = op;
      o.wr_data  = 8'($urandom);
      o.send_ack = 1'($urandom);
      o.rd_data  = 8'($urandom);
      o.polls    = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 6)) : 16'($urandom);
      o.low_from = 8'($urandom_range(0, 20));
      // a large budget needs SDA low across a poll end, or the command would run for ages
      if (o.polls > 16'd20)
         o.low_to = o.low_from + 8'($urandom_range(2, 12));
      else if ($urandom_range(0, 5) == 0)
         o.low_to = 8'd255;
      else
         o.low_to = o.low_from + 8'($urandom_range(0, 12));
      o.typed    = 1'b0;
      o.exp_rx   = 8'h00;
      o.exp_stat = i2cms_pkg::STAT_ACKED;
      return o;
   endfunction

   // Sender: bursts of back-to-back ticks separated by random gaps.
   task automatic offer_tick(input i2cms_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Runs one command to its final tick, playing the slave on SDA and throwing in
   // commands while busy, which the block must ignore.
   task automatic run_op(input bus_op_type o);
      i2cms_pkg::req_type r;
      i2cms_pkg::rsp_type p;
      int      k;
      logic    last;
      k = 0;
      do begin
         r.cmd_valid      = (k == 0) ? o.go       : ($urandom_range(0, 3) == 0);
         r.command        = (k == 0) ? o.op       : 3'($urandom_range(0, 7));
         r.tx_byte        = (k == 0) ? o.wr_data  : 8'($urandom);
         r.ack_after_read = (k == 0) ? o.send_ack : 1'($urandom);
         r.ack_timeout    = (k == 0) ? o.polls    : 16'($urandom);
         if (o.op == i2cms_pkg::CMD_READ)
            r.sda_in = o.rd_data[bit_pos];
         else if (o.op == i2cms_pkg::CMD_WAIT_ACK)
            r.sda_in = !(k >= o.low_from && k < o.low_to);
         else
            r.sda_in = 1'($urandom);
         offer_tick(r);
         p = bus_tick(r);
         last = p.done_res || !p.busy_res;
         if (last && o.typed) begin
            p.rx_byte    = o.exp_rx;
            p.ack_status = o.exp_stat;
         end
         bus_levels_q.push_back(p);
         if (p.busy_res)
            busy_ticks++;
         k++;
      end while (!last);
   endtask

   initial begin : stimulus
      bus_op_type filler;
      int         n;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      seq      = SQ_IDLE;
      tick_cnt = 3'd0;
      bit_pos  = 3'd7;
      shreg    = 8'h00;
      rx_hold  = 8'h00;
      budget   = 17'd0;
      scl_lvl  = 1'b1;
      sda_lvl  = 1'b1;
      ack_sel  = 1'b0;
      status   = i2cms_pkg::STAT_ACKED;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(SCRIPT); i++)
         run_op(SCRIPT[i]);

      busy_ticks = 0;
      while (busy_ticks < RANDOM_TICKS) begin
         if ($urandom_range(0, 9) < 8) begin
            // well-formed transfer: start, address, data phases, stop
            run_op(rand_op(i2cms_pkg::CMD_START));
            run_op(rand_op(i2cms_pkg::CMD_WRITE));
            run_op(rand_op(i2cms_pkg::CMD_WAIT_ACK));
            n = $urandom_range(1, 3);
            repeat (n) begin
               if ($urandom_range(0, 1)) begin
                  run_op(rand_op(i2cms_pkg::CMD_WRITE));
                  run_op(rand_op(i2cms_pkg::CMD_WAIT_ACK));
               end else begin
                  run_op(rand_op(i2cms_pkg::CMD_READ));
               end
            end
            run_op(rand_op(i2cms_pkg::CMD_STOP));
         end else begin
            filler = rand_op(3'($urandom_range(0, 7)));
            filler.go = 1'($urandom);
            run_op(filler);
         end
         n = $urandom_range(0, 2);
         repeat (n) begin
            filler = rand_op(3'($urandom_range(0, 7)));
            filler.go = 1'b0;
            run_op(filler);
         end
      end
      req_if.valid <= 1'b0;

      while (bus_levels_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0 && bus_levels_q.size() == 0)
         $display("i2c_master_bit_sequencer verification clean");
      else
         $display("i2c_master_bit_sequencer verification failed");
      $finish;
   end

   // Receiver: a random stall pattern on ready, plus one long hold-off so the block backs up
   // and stops taking ticks.
   initial begin : rsp_pace
      logic [7:0] pace;
      logic       held_off;
      int         cyc;
      pace     = 8'hFF;
      held_off = 1'b0;
      cyc      = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && rsp_seen >= 200) begin
            held_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end
         if (cyc % 32 == 0)
            pace = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
         rsp_if.ready <= pace[cyc % 8];
         cyc++;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      i2cms_pkg::rsp_type want;
      i2cms_pkg::rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         rsp_seen++;
         if (bus_levels_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("tick %0d: response with nothing expected", rsp_seen);
         end else begin
            want = bus_levels_q.pop_front();
            if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                got.rx_byte !== want.rx_byte || got.ack_status !== want.ack_status) begin
               failures++;
               if (failures <= 10)
                  $display({"tick %0d exp/got: scl %b/%b sda %b/%b busy %b/%b done %b/%b",
                            " rx %h/%h status %0d/%0d"}, rsp_seen,
                           want.scl_out, got.scl_out, want.sda_out, got.sda_out,
                           want.busy_res, got.busy_res, want.done_res, got.done_res,
                           want.rx_byte, got.rx_byte, want.ack_status, got.ack_status);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("i2c_master_bit_sequencer verification failed");
            $finish;
         end
      end
   end

endmodule
